// ===== src/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies; every property is clocked and gated by an active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: property violated");

// next-cycle implication
`define DSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: property violated");

`endif

// ===== src/dsr_pkg.sv =====
// shared types and constants for the d-separation reachability block
// no dependencies
`timescale 1ns / 1ps

package dsr_pkg;

	localparam int NODE_W  = 6;
	localparam int FUNC_W  = 2;
	localparam int MASK_W  = 64;
	localparam int COUNT_W = 7;

	typedef logic [NODE_W-1:0] node_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD   = 2'd0,
		FN_MARK  = 2'd1,
		FN_QUERY = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_ANC_RD,
		ST_ANC_WR,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_DONE
	} state_t;

	// requests to the adjacency store
	typedef enum logic [1:0] {
		GS_NOP,
		GS_READ,
		GS_ADD,
		GS_CLEAR
	} gs_op_t;

	typedef struct packed {
		gs_op_t op;
		node_t  node_a;   // read node, or tail of an added edge
		node_t  node_b;   // head of an added edge
	} gs_req_t;

endpackage

// ===== src/dsr_channels.sv =====
// valid/ready channel interfaces for command items and result items
// depends on dsr_pkg
`timescale 1ns / 1ps

interface dsr_in_if;
	import dsr_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	node_t             parent_node;
	node_t             child_node;
	node_t             observed_node;
	node_t             source_node;
	logic              start_upward;

	modport source (
		output valid, func, parent_node, child_node, observed_node, source_node,
			start_upward,
		input  ready
	);
	modport sink (
		input  valid, func, parent_node, child_node, observed_node, source_node,
			start_upward,
		output ready
	);
endinterface

interface dsr_out_if;
	import dsr_pkg::*;

	logic               valid;
	logic               ready;
	logic [MASK_W-1:0]  reachable_mask;
	logic [COUNT_W-1:0] reachable_count;

	modport source (output valid, reachable_mask, reachable_count, input ready);
	modport sink   (input valid, reachable_mask, reachable_count, output ready);
endinterface

// ===== src/dsr_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dsr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/dsr_lowbit.sv =====
// lowest set bit finder used to pick the next node from a worklist
// no dependencies
`timescale 1ns / 1ps

module dsr_lowbit #(
	parameter int W = 64,
	localparam int IW = $clog2(W)
) (
	input  logic [W-1:0]  vec,
	output logic [IW-1:0] idx,
	output logic          any
);

	always_comb begin
		idx = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IW'(i);
			end
		end
		any = |vec;
	end

endmodule

// ===== src/dsr_graph.sv =====
// adjacency store: parent rows and child rows in two rams, with per-row valid bits
// depends on dsr_pkg and dsr_ram; an edge add is a read then a write in the next cycle
`timescale 1ns / 1ps

module dsr_graph #(
	parameter int LIVE = 64,
	localparam int AW = $clog2(LIVE)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dsr_pkg::gs_req_t req,
	output logic [LIVE-1:0] prow,
	output logic [LIVE-1:0] crow
);
	import dsr_pkg::*;

	localparam logic [LIVE-1:0] ONE = LIVE'(1);

	logic [LIVE-1:0] pvalid_q;
	logic [LIVE-1:0] cvalid_q;
	logic            pv_s1;
	logic            cv_s1;
	logic            add_s1;
	logic [AW-1:0]   pa_s1;
	logic [AW-1:0]   cb_s1;

	logic            rd_en;
	logic [AW-1:0]   p_raddr;
	logic [AW-1:0]   c_raddr;
	logic [LIVE-1:0] p_rdata;
	logic [LIVE-1:0] c_rdata;
	logic [LIVE-1:0] p_wdata;
	logic [LIVE-1:0] c_wdata;

	// parent row of the head, child row of the tail for an add
	assign rd_en   = (req.op == GS_READ) || (req.op == GS_ADD);
	assign p_raddr = (req.op == GS_ADD) ? req.node_b[AW-1:0] : req.node_a[AW-1:0];
	assign c_raddr = req.node_a[AW-1:0];

	// rows never written since reset or clear read as empty
	assign prow = p_rdata & {LIVE{pv_s1}};
	assign crow = c_rdata & {LIVE{cv_s1}};

	assign p_wdata = prow | (ONE << pa_s1);
	assign c_wdata = crow | (ONE << cb_s1);

	dsr_ram #(.WIDTH(LIVE), .DEPTH(LIVE)) u_parent_ram (
		.clk   (clk),
		.we    (add_s1),
		.waddr (cb_s1),
		.wdata (p_wdata),
		.re    (rd_en),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	dsr_ram #(.WIDTH(LIVE), .DEPTH(LIVE)) u_child_ram (
		.clk   (clk),
		.we    (add_s1),
		.waddr (pa_s1),
		.wdata (c_wdata),
		.re    (rd_en),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
			cvalid_q <= '0;
			add_s1   <= 1'b0;
		end else begin
			add_s1 <= (req.op == GS_ADD);
			if (req.op == GS_CLEAR) begin
				pvalid_q <= '0;
				cvalid_q <= '0;
			end else if (add_s1) begin
				pvalid_q[cb_s1] <= 1'b1;
				cvalid_q[pa_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pv_s1 <= pvalid_q[p_raddr];
			cv_s1 <= cvalid_q[c_raddr];
			pa_s1 <= req.node_a[AW-1:0];
			cb_s1 <= req.node_b[AW-1:0];
		end
	end

endmodule

// ===== src/d_separation_reachable_nodes.sv =====
// Bayes-ball d-separation reachability over a DAG held in two adjacency rams.
// An add-edge, mark or clear item passes through a settle state. A query builds
// the ancestor closure of the observed set, then walks the (node, direction)
// pairs reachable from the source; through the one registered read port of each
// adjacency ram, every expanded node costs one row read and then one merge step.
// Nodes at or above min(NODES,64) are ignored on add and mark, and a query from
// such a source returns an empty mask. Reset and clear empty the graph at once
// through per-row valid bits; no clearing pass. A finished result waits in an
// output register while new items are taken; a further query only stalls at its
// end if that register is still full.
// Depends on dsr_pkg, dsr_channels, dsr_graph, dsr_lowbit and dsr_ram.
`timescale 1ns / 1ps

module d_separation_reachable_nodes #(
	parameter int NODES = 64
) (
	input logic       clk,
	input logic       arst_n,
	dsr_in_if.sink    cmd,
	dsr_out_if.source res
);
	import dsr_pkg::*;

	// nodes actually held, and widths that follow from it
	localparam int LIVE = (NODES < MASK_W) ? NODES : MASK_W;
	localparam int AW   = $clog2(LIVE);
	localparam int CW   = $clog2(LIVE + 1);
	localparam logic [NODE_W:0]  LIVE_N = (NODE_W + 1)'(LIVE);
	localparam logic [LIVE-1:0]  ONE    = LIVE'(1);

	state_t state_q, state_d;

	// evidence and per-query working sets
	logic [LIVE-1:0] observed_q;
	logic [LIVE-1:0] ancestor_q;
	logic [LIVE-1:0] vis_up_q;
	logic [LIVE-1:0] vis_dn_q;
	logic [LIVE-1:0] pend_up_q;   // also the ancestor worklist
	logic [LIVE-1:0] pend_dn_q;
	logic [LIVE-1:0] reach_q;
	logic [CW-1:0]   cnt_q;

	logic [AW-1:0]   y_q;
	logic            dir_up_q;
	logic [AW-1:0]   src_q;
	logic            start_up_q;

	// result register
	logic               res_valid_q;
	logic [MASK_W-1:0]  mask_q;
	logic [COUNT_W-1:0] count_q;

	gs_req_t         greq;
	logic [LIVE-1:0] prow;
	logic [LIVE-1:0] crow;

	logic            accept;
	func_t           fn;
	logic            edge_ok;
	logic            obs_ok;
	logic            src_ok;
	logic [LIVE-1:0] sel_vec;
	logic [AW-1:0]   pick_idx;
	logic            pick_any;
	logic [LIVE-1:0] pick_bit;
	logic [LIVE-1:0] y_bit;
	logic            y_obs;
	logic            y_anc;
	logic [LIVE-1:0] go_up;
	logic [LIVE-1:0] go_dn;
	logic            load_res;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign fn        = func_t'(cmd.func);

	// range checks against the held node count
	assign edge_ok = ({1'b0, cmd.parent_node} < LIVE_N) && ({1'b0, cmd.child_node} < LIVE_N);
	assign obs_ok  = ({1'b0, cmd.observed_node} < LIVE_N);
	assign src_ok  = ({1'b0, cmd.source_node} < LIVE_N);

	// up pairs before down pairs, lowest node first
	assign sel_vec  = (pend_up_q != '0) ? pend_up_q : pend_dn_q;
	assign pick_bit = ONE << pick_idx;

	dsr_lowbit #(.W(LIVE)) u_pick (
		.vec (sel_vec),
		.idx (pick_idx),
		.any (pick_any)
	);

	dsr_graph #(.LIVE(LIVE)) u_graph (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (greq),
		.prow   (prow),
		.crow   (crow)
	);

	// walk rules for the pair whose rows have just come back
	assign y_bit = ONE << y_q;
	assign y_obs = observed_q[y_q];
	assign y_anc = ancestor_q[y_q];
	// up through an unobserved node, or down into an active v-structure
	assign go_up = dir_up_q ? (y_obs ? '0 : prow) : (y_anc ? prow : '0);
	// onward to children whenever the node is unobserved
	assign go_dn = y_obs ? '0 : crow;

	assign load_res = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	assign res.valid           = res_valid_q;
	assign res.reachable_mask  = mask_q;
	assign res.reachable_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and store requests
	always_comb begin
		state_d = state_q;
		greq    = '{op: GS_NOP, node_a: '0, node_b: '0};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (fn)
						FN_ADD: begin
							if (edge_ok) begin
								greq = '{op: GS_ADD, node_a: cmd.parent_node,
									node_b: cmd.child_node};
							end
							state_d = ST_SETTLE;
						end
						FN_CLEAR: begin
							greq.op = GS_CLEAR;
							state_d = ST_SETTLE;
						end
						FN_QUERY: begin
							state_d = src_ok ? ST_ANC_RD : ST_DONE;
						end
						default: begin
							state_d = ST_SETTLE;
						end
					endcase
				end
			end
			ST_SETTLE: begin
				// write half of an edge add lands here
				state_d = ST_IDLE;
			end
			ST_ANC_RD: begin
				if (pend_up_q == '0) begin
					state_d = ST_WALK_RD;
				end else begin
					greq    = '{op: GS_READ, node_a: NODE_W'(pick_idx), node_b: '0};
					state_d = ST_ANC_WR;
				end
			end
			ST_ANC_WR: begin
				state_d = ST_ANC_RD;
			end
			ST_WALK_RD: begin
				if (!pick_any) begin
					state_d = ST_DONE;
				end else begin
					greq    = '{op: GS_READ, node_a: NODE_W'(pick_idx), node_b: '0};
					state_d = ST_WALK_WR;
				end
			end
			ST_WALK_WR: begin
				state_d = ST_WALK_RD;
			end
			ST_DONE: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// working sets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			observed_q <= '0;
			ancestor_q <= '0;
			vis_up_q   <= '0;
			vis_dn_q   <= '0;
			pend_up_q  <= '0;
			pend_dn_q  <= '0;
			reach_q    <= '0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (fn)
							FN_MARK: begin
								if (obs_ok) begin
									observed_q <= observed_q |
										(ONE << cmd.observed_node[AW-1:0]);
								end
							end
							FN_CLEAR: begin
								observed_q <= '0;
							end
							FN_QUERY: begin
								// ancestor closure is seeded by the evidence only
								ancestor_q <= observed_q;
								pend_up_q  <= observed_q;
								pend_dn_q  <= '0;
								reach_q    <= '0;
								cnt_q      <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ANC_RD: begin
					if (pend_up_q == '0) begin
						// closure done, seed the walk with the source pair
						vis_up_q  <= '0;
						vis_dn_q  <= '0;
						pend_up_q <= start_up_q ? (ONE << src_q) : '0;
						pend_dn_q <= start_up_q ? '0 : (ONE << src_q);
					end else begin
						pend_up_q <= pend_up_q & ~pick_bit;
					end
				end
				ST_ANC_WR: begin
					ancestor_q <= ancestor_q | prow;
					pend_up_q  <= pend_up_q | (prow & ~ancestor_q);
				end
				ST_WALK_RD: begin
					if (pick_any) begin
						if (pend_up_q != '0) begin
							pend_up_q <= pend_up_q & ~pick_bit;
							vis_up_q  <= vis_up_q | pick_bit;
						end else begin
							pend_dn_q <= pend_dn_q & ~pick_bit;
							vis_dn_q  <= vis_dn_q | pick_bit;
						end
					end
				end
				ST_WALK_WR: begin
					pend_up_q <= pend_up_q | (go_up & ~vis_up_q);
					pend_dn_q <= pend_dn_q | (go_dn & ~vis_dn_q);
					if (!y_obs) begin
						reach_q <= reach_q | y_bit;
						// running popcount of the reach set
						if (!reach_q[y_q]) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// query operands and the node in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q      <= cmd.source_node[AW-1:0];
			start_up_q <= cmd.start_upward;
		end
		if (state_q == ST_ANC_RD || state_q == ST_WALK_RD) begin
			y_q      <= pick_idx;
			dir_up_q <= (pend_up_q != '0);
		end
	end

	// result register, refilled in the cycle the old item leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			mask_q  <= MASK_W'(reach_q);
			count_q <= COUNT_W'(cnt_q);
		end
	end

endmodule

// ===== src/dsr_checker.sv =====
// port-level checks on the reachability block, bound to its top level
// depends on assert_macros.svh and d_separation_reachable_nodes
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [63:0] mask,
	input logic [6:0]  count
);

	// a stalled result item stays offered and unchanged
	`DSR_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`DSR_ASSERT_NXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(mask) && $stable(count))

	// the count always agrees with the mask
	`DSR_ASSERT_IMP(a_count_pop, clk, arst_n, res_valid, $countones(mask) == 32'(count))

	// every accepted item leaves the block busy in the next cycle
	`DSR_ASSERT_NXT(a_busy_after_item, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind d_separation_reachable_nodes dsr_checker u_dsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.mask      (res.reachable_mask),
	.count     (res.reachable_count)
);
